### design/sfq_pkg.sv
`default_nettype none
package sfq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int POS_W  = 10;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

### design/sfq_cell.sv
`default_nettype none
module sfq_cell (
    input  wire logic                      i_clk,
    input  wire sfq_pkg::t_cell_ctl        i_ctl,
    input  wire logic [sfq_pkg::DATA_W-1:0] i_value,
    input  wire logic [sfq_pkg::DATA_W-1:0] i_next_data,
    output logic      [sfq_pkg::DATA_W-1:0] o_data,
    output logic                           o_match
);

    logic [sfq_pkg::DATA_W-1:0] r_data;
    logic [sfq_pkg::DATA_W-1:0] n_data;
    logic                       r_match;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shift) begin
            n_data = i_next_data;
        end
    end

    // compare runs every cycle, sampled by the sequencer in the cycle after a search is accepted
    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= (r_data == i_value);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule
`default_nettype wire

### design/sfq_pick.sv
`default_nettype none
module sfq_pick (
    input  wire logic [sfq_pkg::DEPTH-1:0] i_match,
    input  wire logic [sfq_pkg::CNT_W-1:0] i_count,
    output logic                           o_found,
    output logic      [sfq_pkg::POS_W-1:0] o_position
);

    // lowest live cell that matched wins
    always_comb begin
        o_found    = 1'b0;
        o_position = '0;
        for (int i = sfq_pkg::DEPTH - 1; i >= 0; i--) begin
            if (i_match[i] && (sfq_pkg::CNT_W'(i) < i_count)) begin
                o_found    = 1'b1;
                o_position = sfq_pkg::POS_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

### design/searchable_fifo_queue.sv
`default_nettype none
// Searchable FIFO of signed 32-bit words held in a row of shift cells, cell 0
// being the head. Each transaction on the slave side carries the action in
// s_tuser and the value in s_tdata and yields exactly one result transaction.
// Insert writes the cell just past the last live one, remove returns cell 0
// and shifts every cell one place toward the head, and search compares all
// cells against the value at once. Insert, remove and the unused action code
// go straight to the result register; search registers the compare of every
// cell before the priority pick of the first live match. A new transaction is
// taken as soon as the queue is idle and the result register is free or being
// emptied in that cycle, so insert and remove sustain one operation per cycle
// while results drain, and a search holds off the next until its pick is done.
module searchable_fifo_queue (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [sfq_pkg::DATA_W-1:0]          s_tdata,  // value
    input  wire logic [sfq_pkg::ACT_W-1:0]           s_tuser,  // action
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [sfq_pkg::OUT_TDATA_W-1:0]     m_tdata,  // data_out, position, zero pad
    output logic      [sfq_pkg::STAT_W-1:0]          m_tuser   // status
);

    typedef enum logic {
        S_IDLE,
        S_PICK
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [sfq_pkg::CNT_W-1:0]   r_count;
    logic [sfq_pkg::CNT_W-1:0]   n_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    sfq_pkg::t_status            r_status;
    sfq_pkg::t_status            n_status;
    logic [sfq_pkg::DATA_W-1:0]  r_data_out;
    logic [sfq_pkg::DATA_W-1:0]  n_data_out;
    logic [sfq_pkg::POS_W-1:0]   r_position;
    logic [sfq_pkg::POS_W-1:0]   n_position;

    logic                        in_xfer;
    logic                        out_xfer;
    sfq_pkg::t_action            action;
    logic                        do_insert;
    logic                        do_remove;
    logic                        pick_found;
    logic [sfq_pkg::POS_W-1:0]   pick_position;

    sfq_pkg::t_cell_ctl          cell_ctl  [sfq_pkg::DEPTH];
    logic [sfq_pkg::DATA_W-1:0]  cell_data [sfq_pkg::DEPTH];
    logic [sfq_pkg::DEPTH-1:0]   cell_match;

    assign action   = sfq_pkg::t_action'(s_tuser);
    assign out_xfer = r_out_valid && m_tready;
    assign s_tready = (r_state == S_IDLE) && (!r_out_valid || m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    assign do_insert = in_xfer && (action == sfq_pkg::ACT_INSERT)
                       && (r_count != sfq_pkg::CNT_W'(sfq_pkg::DEPTH));
    assign do_remove = in_xfer && (action == sfq_pkg::ACT_REMOVE)
                       && (r_count != '0);

    for (genvar g = 0; g < sfq_pkg::DEPTH; g++) begin : g_cell
        logic [sfq_pkg::DATA_W-1:0] next_data;

        if (g == sfq_pkg::DEPTH - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end

        assign cell_ctl[g].load  = do_insert && (r_count == sfq_pkg::CNT_W'(g));
        assign cell_ctl[g].shift = do_remove;

        sfq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_value     (s_tdata),
            .i_next_data (next_data),
            .o_data      (cell_data[g]),
            .o_match     (cell_match[g])
        );
    end

    sfq_pick u_pick (
        .i_match    (cell_match),
        .i_count    (r_count),
        .o_found    (pick_found),
        .o_position (pick_position)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !out_xfer;
        n_status    = r_status;
        n_data_out  = r_data_out;
        n_position  = r_position;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_status   = sfq_pkg::ST_OK;
                    n_data_out = '0;
                    n_position = '0;
                    case (action)
                        sfq_pkg::ACT_INSERT: begin
                            if (do_insert) begin
                                n_count = r_count + sfq_pkg::CNT_W'(1);
                            end else begin
                                n_status = sfq_pkg::ST_FULL;
                            end
                            n_out_valid = 1'b1;
                        end
                        sfq_pkg::ACT_REMOVE: begin
                            if (do_remove) begin
                                n_count    = r_count - sfq_pkg::CNT_W'(1);
                                n_data_out = cell_data[0];
                            end else begin
                                n_status = sfq_pkg::ST_EMPTY;
                            end
                            n_out_valid = 1'b1;
                        end
                        sfq_pkg::ACT_SEARCH: begin
                            // cells register their compare this cycle
                            n_state = S_PICK;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_PICK: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_data_out  = '0;
                if (pick_found) begin
                    n_status   = sfq_pkg::ST_OK;
                    n_position = pick_position;
                end else begin
                    n_status   = sfq_pkg::ST_NOTFOUND;
                    n_position = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_status   <= n_status;
        r_data_out <= n_data_out;
        r_position <= n_position;
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = {{(sfq_pkg::OUT_TDATA_W - sfq_pkg::DATA_W - sfq_pkg::POS_W){1'b0}},
                       r_position, r_data_out};

endmodule
`default_nettype wire

### bench/sfq_checker.sv
`timescale 1ns / 100ps
module sfq_checker
    import sfq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [DATA_W-1:0]      i_s_tdata,   // value
    input  wire logic [ACT_W-1:0]       i_s_tuser,   // action
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,   // data_out, position, zero pad
    input  wire logic [STAT_W-1:0]      i_m_tuser,   // status
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] data_out;
        logic [POS_W-1:0]  position;
    } t_op_result;

    t_op_result        queue_results[$];
    logic [DATA_W-1:0] shadow_store [DEPTH];
    int unsigned       shadow_head;
    int unsigned       shadow_tail;
    int unsigned       shadow_count;

    // applies one operation to the shadow queue and returns its outcome
    function automatic t_op_result apply_queue_op(t_action act, logic [DATA_W-1:0] val);
        t_op_result  r;
        int unsigned idx;
        r.status   = ST_OK;
        r.data_out = '0;
        r.position = '0;
        case (act)
            ACT_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_store[shadow_tail] = val;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_count++;
                end
            end
            ACT_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            ACT_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (int k = 0; k < shadow_count; k++) begin
                    idx = (shadow_head + k) % DEPTH;
                    if (shadow_store[idx] == val) begin
                        r.status   = ST_OK;
                        r.position = POS_W'(k);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_op_result                       want;
        logic [DATA_W-1:0]                got_data;
        logic [POS_W-1:0]                 got_pos;
        logic [OUT_TDATA_W-DATA_W-POS_W-1:0] got_pad;
        if (!i_rst_n) begin
            queue_results.delete();
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_count = 0;
        end else begin
            // results first: a result never leaves in the cycle its operation enters
            if (i_m_tvalid && i_m_tready) begin
                got_data = i_m_tdata[DATA_W-1:0];
                got_pos  = i_m_tdata[DATA_W +: POS_W];
                got_pad  = i_m_tdata[OUT_TDATA_W-1:DATA_W+POS_W];
                if (queue_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display({"[%0t] result transaction with nothing pending: ",
                                  "status %0d data %h pos %0d"},
                                 $realtime, i_m_tuser, got_data, got_pos);
                end else begin
                    want = queue_results.pop_front();
                    if (i_m_tuser != want.status || got_data != want.data_out ||
                        got_pos != want.position || got_pad != '0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] mismatch: expected status %0d data %h ",
                                      "pos %0d pad 0, got status %0d data %h ",
                                      "pos %0d pad %h"},
                                     $realtime, want.status, want.data_out, want.position,
                                     i_m_tuser, got_data, got_pos, got_pad);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                queue_results.push_back(apply_queue_op(t_action'(i_s_tuser), i_s_tdata));
        end
        o_pending = queue_results.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import sfq_pkg::*;

    localparam int RANDOM_OPS  = 2000;
    localparam int QUIET_TAIL  = 300;
    localparam int CYCLE_LIMIT = 300000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;   // value
    logic [ACT_W-1:0]       s_tuser;   // action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // data_out, position, zero pad
    logic [STAT_W-1:0]      m_tuser;   // status
    int                     fail_count;
    int                     pending_ops;
    bit                     quiet_mode;
    bit                     hold_request;

    searchable_fifo_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sfq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_ops)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int burst;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (64) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (burst) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // offers one operation and returns at the falling edge after it is taken
    task automatic put_op(t_action act, logic [DATA_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    initial begin
        logic [DATA_W-1:0] value_pool [8];
        logic [DATA_W-1:0] last_insert;
        logic [DATA_W-1:0] val;
        t_action           act;
        int                mode;
        int                pick;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        quiet_mode   = 1'b0;
        hold_request = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue cases and the unused action
        put_op(ACT_REMOVE, 32'h5a5a_5a5a);
        put_op(ACT_SEARCH, 32'h0000_0000);
        put_op(ACT_NOP,    32'hffff_ffff);
        // fill to the brim with extremes and a duplicate
        put_op(ACT_INSERT, 32'h8000_0000);
        put_op(ACT_INSERT, 32'h7fff_ffff);
        put_op(ACT_INSERT, 32'h0000_0000);
        put_op(ACT_INSERT, 32'hffff_ffff);
        put_op(ACT_INSERT, 32'h0000_0001);
        put_op(ACT_INSERT, 32'h7fff_ffff);
        for (int k = 0; k < DEPTH - 6; k++) begin
            last_insert = $urandom;
            put_op(ACT_INSERT, last_insert);
        end
        put_op(ACT_INSERT, 32'h1357_9bdf);
        put_op(ACT_SEARCH, 32'h7fff_ffff);  // oldest of the two copies
        put_op(ACT_SEARCH, 32'h8000_0000);  // head entry
        put_op(ACT_SEARCH, last_insert);    // tail entry
        put_op(ACT_SEARCH, 32'h1357_9bdf);
        put_op(ACT_REMOVE, 32'h0000_0000);

        value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                       32'h0000_0001, 32'h0000_00ff, 32'hdead_beef, 32'h0123_4567};
        mode = 0;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 50 == 0) begin
                mode = $urandom_range(0, 2);
                value_pool[$urandom_range(4, 7)] = $urandom;
            end
            if (i == RANDOM_OPS - QUIET_TAIL)
                quiet_mode = 1'b1;
            if (i == 600)
                hold_request = 1'b1;
            if (!quiet_mode && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            if (i == 1200) begin
                // drain everything before going on
                s_tvalid <= 1'b0;
                do @(negedge i_clk); while (pending_ops != 0);
            end

            pick = $urandom_range(0, 99);
            case (mode)
                0: act = (pick < 55) ? ACT_INSERT : (pick < 75) ? ACT_REMOVE :
                         (pick < 97) ? ACT_SEARCH : ACT_NOP;
                1: act = (pick < 20) ? ACT_INSERT : (pick < 65) ? ACT_REMOVE :
                         (pick < 97) ? ACT_SEARCH : ACT_NOP;
                default: act = (pick < 35) ? ACT_INSERT : (pick < 65) ? ACT_REMOVE :
                               (pick < 97) ? ACT_SEARCH : ACT_NOP;
            endcase

            pick = $urandom_range(0, 3);
            if (act == ACT_INSERT) begin
                val = (pick < 2) ? value_pool[$urandom_range(0, 7)] : $urandom;
                last_insert = val;
            end else if (act == ACT_SEARCH) begin
                val = (pick < 2) ? value_pool[$urandom_range(0, 7)] :
                      (pick == 2) ? last_insert : $urandom;
            end else begin
                val = $urandom;
            end
            put_op(act, val);
        end

        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_ops != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_ops == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
